@@ hw/rtl/pending_request_table_timeout_unit_assert.svh @@
// ----------------------------------------------------------------------------
// pending request table assertion macros
// wrappers around concurrent assertions, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef PENDING_REQUEST_TABLE_TIMEOUT_UNIT_ASSERT_SVH
`define PENDING_REQUEST_TABLE_TIMEOUT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PRTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PRTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PRTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/prtt_pkg.sv @@
// ----------------------------------------------------------------------------
// prtt_pkg
// types and constants of the pending request table with timeout
// ----------------------------------------------------------------------------
package prtt_pkg;

    localparam int POOL_SLOTS = 512;
    localparam int ADDR_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int ACT_W      = $clog2(POOL_SLOTS + 1);

    localparam int OP_W       = 3;
    localparam int ID_W       = 16;
    localparam int SLOT_W     = 9;
    localparam int TALLY_W    = 10;
    localparam int LIFE_W     = 8;
    localparam int PADDR_W    = 3;

    localparam logic [TALLY_W-1:0] TALLY_MAX     = '1;
    localparam logic [LIFE_W-1:0]  LIFETIME_RST  = 8'd8;

    // register index, taken from paddr[2]
    localparam logic REG_LIFETIME = 1'b0;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   transaction_id;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic               success;
        logic [SLOT_W-1:0]  slot_number;
        logic [TALLY_W-1:0] tally;
    } t_rsp;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life;
    } t_entry;

endpackage

@@ hw/rtl/pending_request_table_timeout_unit.sv @@
// ----------------------------------------------------------------------------
// pending_request_table_timeout_unit
// pool of request slots with id lookup and lifetime aging, held in one ram
// ----------------------------------------------------------------------------
// Requests arrive on the i_req valid/ready channel, one result leaves on the
// o_rsp valid/ready channel for every request. Slot state (valid, id,
// lifetime) lives in a single-port-write, single-port-read synchronous ram
// with a registered read port; the table is worked on one slot a cycle.
// Count and unknown codes need no ram access, delete reads and frees the
// given slot, add and find scan until the first free or matching slot,
// tick ages the whole table and clear all writes every slot free. One request
// is worked on at a time; a new one is taken as soon as the previous
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds the block only when the next one is ready to be
// delivered.
// After reset a clearing pass writes every slot free; i_req is not taken
// during it, the lifetime register (reset 8) can be written over the apb
// port at any time the block is idle.
// ----------------------------------------------------------------------------
`include "pending_request_table_timeout_unit_assert.svh"

module pending_request_table_timeout_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  prtt_pkg::t_req                   i_req,
    output logic                             o_rsp_valid,
    input  logic                             i_rsp_ready,
    output prtt_pkg::t_rsp                   o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [prtt_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import prtt_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DEL,
        ST_CLR,
        ST_DONE
    } t_state;

    t_state              r_state,      n_state;
    logic [OP_W-1:0]     r_op,         n_op;
    logic [ID_W-1:0]     r_tid,        n_tid;
    logic [CNT_W-1:0]    r_cnt,        n_cnt;
    logic                r_chk,        n_chk;
    logic [ADDR_W-1:0]   r_chk_addr,   n_chk_addr;
    logic [TALLY_W-1:0]  r_expired,    n_expired;
    logic [ACT_W-1:0]    r_active,     n_active;
    logic [LIFE_W-1:0]   r_lifetime,   n_lifetime;
    t_rsp                r_res,        n_res;
    logic                r_rsp_valid,  n_rsp_valid;
    t_rsp                r_rsp,        n_rsp;

    t_entry              r_mem [POOL_SLOTS];
    t_entry              r_rd_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    t_entry              mem_wd;
    logic [ADDR_W-1:0]   mem_ra;

    logic                last_chk;
    logic                cfg_wr;
    logic [TALLY_W-1:0]  exp_inc;
    logic [TALLY_W-1:0]  act_tally;
    logic [ACT_W-1:0]    act_dec;

    // slot ram
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_LIFETIME);
    assign prdata  = (paddr[2] == REG_LIFETIME) ? {{(32-LIFE_W){1'b0}}, r_lifetime} : '0;

    assign last_chk  = (r_chk_addr == ADDR_W'(POOL_SLOTS - 1));
    assign exp_inc   = (r_expired == TALLY_MAX) ? r_expired : r_expired + 1'b1;
    assign act_tally = (32'(r_active) > 32'(TALLY_MAX)) ? TALLY_MAX : TALLY_W'(r_active);
    assign act_dec   = (r_active != '0) ? r_active - 1'b1 : r_active;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_tid       = r_tid;
        n_cnt       = r_cnt;
        n_chk       = r_chk;
        n_chk_addr  = r_chk_addr;
        n_expired   = r_expired;
        n_active    = r_active;
        n_lifetime  = cfg_wr ? pwdata[LIFE_W-1:0] : r_lifetime;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        mem_we      = 1'b0;
        mem_wa      = r_chk_addr;
        mem_wd      = '0;
        mem_ra      = r_cnt[ADDR_W-1:0];
        o_req_ready = 1'b0;

        case (r_state)
            ST_INIT, ST_CLR: begin
                // sweep writes every slot free
                mem_we = 1'b1;
                mem_wa = r_cnt[ADDR_W-1:0];
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POOL_SLOTS - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                mem_ra      = ADDR_W'(i_req.slot_index);
                if (i_req_valid) begin
                    n_op       = i_req.operation;
                    n_tid      = i_req.transaction_id;
                    n_res      = '0;
                    n_cnt      = '0;
                    n_chk      = 1'b0;
                    n_expired  = '0;
                    n_chk_addr = ADDR_W'(i_req.slot_index);
                    case (i_req.operation)
                        OP_ADD, OP_FIND, OP_TICK: begin
                            n_state = ST_SCAN;
                        end
                        OP_DEL: begin
                            n_state = (32'(i_req.slot_index) < POOL_SLOTS) ? ST_DEL : ST_DONE;
                        end
                        OP_CLEAR: begin
                            n_active = '0;
                            n_state  = ST_CLR;
                        end
                        OP_COUNT: begin
                            n_res.tally = act_tally;
                            n_state     = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DEL: begin
                if (r_rd_data.valid) begin
                    mem_we        = 1'b1;
                    mem_wd        = r_rd_data;
                    mem_wd.valid  = 1'b0;
                    n_active      = act_dec;
                    n_res.success = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // read slot r_cnt while checking the slot read in the cycle before
                if (32'(r_cnt) < POOL_SLOTS) begin
                    n_cnt      = r_cnt + 1'b1;
                    n_chk      = 1'b1;
                    n_chk_addr = r_cnt[ADDR_W-1:0];
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk) begin
                    case (r_op)
                        OP_ADD: begin
                            if (!r_rd_data.valid) begin
                                mem_we            = 1'b1;
                                mem_wd.valid      = 1'b1;
                                mem_wd.id         = r_tid;
                                mem_wd.life       = r_lifetime;
                                n_active          = r_active + 1'b1;
                                n_res.success     = 1'b1;
                                n_res.slot_number = SLOT_W'(r_chk_addr);
                                n_state           = ST_DONE;
                            end else if (last_chk) begin
                                n_state = ST_DONE;
                            end
                        end
                        OP_FIND: begin
                            if (r_rd_data.valid && (r_rd_data.id == r_tid)) begin
                                n_res.success     = 1'b1;
                                n_res.slot_number = SLOT_W'(r_chk_addr);
                                n_state           = ST_DONE;
                            end else if (last_chk) begin
                                n_state = ST_DONE;
                            end
                        end
                        OP_TICK: begin
                            if (r_rd_data.valid) begin
                                mem_we = 1'b1;
                                if (r_rd_data.life <= LIFE_W'(1)) begin
                                    mem_wd    = '0;
                                    n_expired = exp_inc;
                                    n_active  = act_dec;
                                end else begin
                                    mem_wd      = r_rd_data;
                                    mem_wd.life = r_rd_data.life - 1'b1;
                                end
                            end
                            if (last_chk) begin
                                n_res.tally = n_expired;
                                n_state     = ST_DONE;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_chk       <= 1'b0;
            r_active    <= '0;
            r_lifetime  <= LIFETIME_RST;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_chk       <= n_chk;
            r_active    <= n_active;
            r_lifetime  <= n_lifetime;
            r_rsp_valid <= n_rsp_valid;
            r_op        <= n_op;
            r_tid       <= n_tid;
            r_chk_addr  <= n_chk_addr;
            r_expired   <= n_expired;
            r_res       <= n_res;
            r_rsp       <= n_rsp;
        end
    end

    `PRTT_ASSERT_IMP(a_active_bound, i_clk, i_rst_n, 1'b1, 32'(r_active) <= POOL_SLOTS, "active count above pool size")
    `PRTT_ASSERT_IMP(a_fail_no_slot, i_clk, i_rst_n, o_rsp_valid && !o_rsp.success, o_rsp.slot_number == '0, "slot number set on failed result")
    `PRTT_ASSERT_IMP(a_tally_no_success, i_clk, i_rst_n, o_rsp_valid && (o_rsp.tally != '0), !o_rsp.success, "tally and success both set")
    `PRTT_ASSERT_NXT(a_rsp_drains, i_clk, i_rst_n, o_rsp_valid && i_rsp_ready && (r_state != ST_DONE), !o_rsp_valid, "result repeated after transfer")

endmodule
